// ----- rtl/mbad_pkg.sv -----
// ----------------------------------------------------------------------------
// mbad_pkg
// Shared constants, types and helpers for the main bus address decoder.
// ----------------------------------------------------------------------------
package mbad_pkg;

	// Storage sizes
	localparam int RAM_BYTES_DEF = 12288;
	localparam int PAL_ROWS      = 256;
	localparam int PAL_ROW_W     = 8;

	// Address map
	localparam logic [15:0] ADDR_PORT0    = 16'h3800;
	localparam logic [15:0] ADDR_PORT1    = 16'h3801;
	localparam logic [15:0] ADDR_STATUS   = 16'h3802;
	localparam logic [15:0] ADDR_DIPA     = 16'h3803;
	localparam logic [15:0] ADDR_MCU      = 16'h3804;
	localparam logic [15:0] ADDR_BANK     = 16'h3805;
	localparam logic [15:0] ADDR_NMI_ACK  = 16'h3806;
	localparam logic [15:0] ADDR_IRQ_ACK  = 16'h3807;
	localparam logic [15:0] RAM_TOP       = 16'h3000;
	localparam logic [6:0]  PAL_PAGE      = 7'h18;   // 0x3000-0x31FF, address[15:9]
	localparam logic [4:0]  MIRROR_PAGE   = 5'h04;   // 0x2000-0x27FF, address[15:11]
	localparam logic [15:0] MIRROR_BASE   = 16'h2000;
	localparam logic [8:0]  MIRROR_MASK   = 9'h1ff;
	localparam logic [13:0] ROM_OFS_MASK  = 14'h3fff;
	localparam logic [7:0]  UNMAPPED_BYTE = 8'hff;

	// Side-effect event codes
	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_SOUND_CMD = 3'd1,
		EV_MCU_WRITE = 3'd2,
		EV_MCU_RESET = 3'd3,
		EV_NMI_ACK   = 3'd4,
		EV_IRQ_ACK   = 3'd5
	} event_t;

	// Palette access pushed at the input beat
	typedef struct packed {
		logic                 wr;
		logic                 hi;
		logic [PAL_ROW_W-1:0] row;
		logic [7:0]           data;
	} pal_req_t;

	// Palette row after the access: low byte and high byte
	typedef struct packed {
		logic [7:0] lo;
		logic [7:0] hi;
	} pal_rsp_t;

	// Repeat a nibble into both halves of a byte
	function automatic logic [7:0] nib2(input logic [3:0] n);
		return {n, n};
	endfunction

endpackage

// ----- rtl/mbad_palette.sv -----
// ----------------------------------------------------------------------------
// mbad_palette
// Palette RAM as 256 rows of two bytes with per-row valid bits; reads the
// row at the input beat, merges a write in the following cycle and writes it back.
// ----------------------------------------------------------------------------
module mbad_palette
	import mbad_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pal_req_t req,
	output pal_rsp_t rsp
);

	logic [15:0]          pal_mem [PAL_ROWS];
	logic [15:0]          mem_q;
	logic [PAL_ROWS-1:0]  row_vld_q;
	pal_req_t             req_s1;
	logic                 vld_s1;
	logic                 wb_pend_q;
	logic                 fwd_q;
	logic [15:0]          fwd_data_q;
	logic [15:0]          base_row;
	logic [15:0]          new_row;

	// Merge: forwarded row wins, then stored row, then reset value
	always_comb begin
		if (fwd_q) begin
			base_row = fwd_data_q;
		end else if (vld_s1) begin
			base_row = mem_q;
		end else begin
			base_row = '0;
		end
		new_row = base_row;
		if (req_s1.wr) begin
			if (req_s1.hi) begin
				new_row[15:8] = req_s1.data;
			end else begin
				new_row[7:0] = req_s1.data;
			end
		end
	end

	assign rsp.lo = new_row[7:0];
	assign rsp.hi = new_row[15:8];

	// Memory: read at the beat, write back in the cycle after a write beat
	always_ff @(posedge clk) begin
		if (wb_pend_q) begin
			pal_mem[req_s1.row] <= new_row;
		end
		if (push) begin
			mem_q <= pal_mem[req.row];
		end
	end

	// Hold the request and forward the row being written back
	always_ff @(posedge clk) begin
		if (push) begin
			req_s1     <= req;
			fwd_data_q <= new_row;
		end
	end

	// Control: writeback pending, forward select, row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_pend_q <= 1'b0;
			fwd_q     <= 1'b0;
			vld_s1    <= 1'b0;
			row_vld_q <= '0;
		end else begin
			wb_pend_q <= push & req.wr;
			if (push) begin
				fwd_q  <= wb_pend_q && (req.row == req_s1.row);
				vld_s1 <= row_vld_q[req.row];
			end
			if (wb_pend_q) begin
				row_vld_q[req_s1.row] <= 1'b1;
			end
		end
	end

	a_wb_once: assert property (@(posedge clk) disable iff (!arst_n)
		wb_pend_q && !push |=> !wb_pend_q)
		else $error("palette writeback repeated");
	a_wb_follows: assert property (@(posedge clk) disable iff (!arst_n)
		push && req.wr |=> wb_pend_q)
		else $error("palette write not written back");
	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		push && !wb_pend_q |=> !fwd_q)
		else $error("palette forward without writeback");

endmodule

// ----- rtl/main_bus_address_decoder.sv -----
// ----------------------------------------------------------------------------
// main_bus_address_decoder
// Decodes one main CPU bus access per beat: work RAM, palette RAM, ROM bank,
// scroll registers and the I/O page, with one result beat per access.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------------
//  input    | in_valid / in_ready    | req_type, address, write_data, ports
//  output   | out_valid / out_ready  | read_data, rom_*, scroll, event, palette
//  config   | cfg_wr_en              | cfg_wr_data (DIP bank A)
//
//  One access a cycle while the output is not stalled; a result appears in the cycle after its beat.
//  Work RAM and palette RAM are read at the input beat; palette writes
//  merge and write back in the following cycle.
//  Reset leaves work RAM undefined; palette rows read zero until written.
//  A stalled result holds in the output stage; the next beat is taken in
//  the cycle the result leaves.
// ----------------------------------------------------------------------------
module main_bus_address_decoder
	import mbad_pkg::*;
#(
	parameter int RAM_BYTES = RAM_BYTES_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  player_port_0,
	input  logic [7:0]  player_port_1,
	input  logic [7:0]  dip_bank_b_live,
	input  logic        mcu_host_sent,
	input  logic        mcu_reply_sent,
	input  logic [7:0]  mcu_reply_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        rom_read,
	output logic [15:0] rom_address,
	output logic [9:0]  scroll_offset,
	output logic [2:0]  side_event,
	output logic [7:0]  event_data,
	output logic        palette_valid,
	output logic [7:0]  palette_index,
	output logic [23:0] palette_rgb
);

	localparam int RAM_AW = $clog2(RAM_BYTES);

	logic [7:0]        work_ram [RAM_BYTES];
	logic [7:0]        wram_s1;
	logic [7:0]        dip_a_q;
	logic              bank_q;
	logic [15:0]       scroll_x_q;
	logic              comp_q;
	logic              accept;
	logic              ram_hit;
	logic [15:0]       slot;
	logic [RAM_AW-1:0] ram_idx;
	pal_req_t          pal_req;
	pal_rsp_t          pal_rsp;
	logic              pal_push;

	logic              wr_s1;
	logic [15:0]       addr_s1;
	logic [7:0]        wdata_s1;
	logic [7:0]        p0_s1;
	logic [7:0]        p1_s1;
	logic [7:0]        dsb_s1;
	logic              hs_s1;
	logic              rs_s1;
	logic [7:0]        md_s1;
	logic              pal_hit_s1;
	logic              ram_hit_s1;
	logic              rom_hit_s1;
	event_t            ev;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	// Fold the mirrored window onto its 512 bytes
	assign ram_hit = address < RAM_TOP;
	always_comb begin
		if (address[15:11] == MIRROR_PAGE) begin
			slot = MIRROR_BASE | {7'd0, address[8:0] & MIRROR_MASK};
		end else begin
			slot = address;
		end
	end
	assign ram_idx = slot[RAM_AW-1:0];

	// Work RAM: write or read at the input beat
	always_ff @(posedge clk) begin
		if (accept) begin
			if (req_type && ram_hit) begin
				work_ram[ram_idx] <= write_data;
			end
			wram_s1 <= work_ram[ram_idx];
		end
	end

	// Palette RAM
	assign pal_push     = accept && (address[15:9] == PAL_PAGE);
	assign pal_req.wr   = req_type;
	assign pal_req.hi   = address[8];
	assign pal_req.row  = address[7:0];
	assign pal_req.data = write_data;

	mbad_palette u_palette (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (pal_push),
		.req    (pal_req),
		.rsp    (pal_rsp)
	);

	// Register writes land at the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dip_a_q    <= UNMAPPED_BYTE;
			bank_q     <= 1'b0;
			scroll_x_q <= '0;
			comp_q     <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				dip_a_q <= cfg_wr_data;
			end
			if (accept && req_type) begin
				case (address)
					ADDR_PORT0: scroll_x_q[7:0]  <= write_data;
					ADDR_PORT1: scroll_x_q[15:8] <= write_data;
					ADDR_DIPA:  comp_q           <= write_data[0];
					ADDR_BANK:  bank_q           <= write_data[0];
					default: ;
				endcase
			end
		end
	end

	// Output stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	// Output stage payload: hold while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			wr_s1      <= req_type;
			addr_s1    <= address;
			wdata_s1   <= write_data;
			p0_s1      <= player_port_0;
			p1_s1      <= player_port_1;
			dsb_s1     <= dip_bank_b_live;
			hs_s1      <= mcu_host_sent;
			rs_s1      <= mcu_reply_sent;
			md_s1      <= mcu_reply_data;
			pal_hit_s1 <= address[15:9] == PAL_PAGE;
			ram_hit_s1 <= ram_hit;
			rom_hit_s1 <= address[15:14] != 2'b00;
		end
	end

	// Decode the result
	always_comb begin
		read_data  = '0;
		rom_read   = 1'b0;
		rom_address = '0;
		ev         = EV_NONE;
		event_data = '0;
		if (!wr_s1) begin
			if (ram_hit_s1) begin
				read_data = wram_s1;
			end else if (pal_hit_s1) begin
				read_data = addr_s1[8] ? pal_rsp.hi : pal_rsp.lo;
			end else if (rom_hit_s1) begin
				rom_read = 1'b1;
				if (addr_s1[15]) begin
					rom_address = addr_s1;
				end else begin
					rom_address = {1'b0, bank_q, addr_s1[13:0] & ROM_OFS_MASK};
				end
			end else begin
				case (addr_s1)
					ADDR_PORT0:  read_data = p0_s1;
					ADDR_PORT1:  read_data = p1_s1;
					ADDR_STATUS: read_data = dsb_s1 | {2'b00, ~rs_s1, ~hs_s1, 4'b0000};
					ADDR_DIPA:   read_data = dip_a_q;
					ADDR_MCU:    read_data = md_s1;
					ADDR_BANK:   ev = EV_MCU_RESET;
					default:     read_data = UNMAPPED_BYTE;
				endcase
			end
		end else begin
			case (addr_s1)
				ADDR_STATUS: begin
					ev         = EV_SOUND_CMD;
					event_data = wdata_s1;
				end
				ADDR_MCU: begin
					ev         = EV_MCU_WRITE;
					event_data = wdata_s1;
				end
				ADDR_NMI_ACK: ev = EV_NMI_ACK;
				ADDR_IRQ_ACK: ev = EV_IRQ_ACK;
				default: ;
			endcase
		end
	end

	assign side_event    = ev;
	assign scroll_offset = {scroll_x_q[9:8] - {1'b0, comp_q}, scroll_x_q[7:0]};
	assign palette_valid = wr_s1 && pal_hit_s1;
	assign palette_index = palette_valid ? addr_s1[7:0] : 8'd0;
	assign palette_rgb   = palette_valid ?
		{nib2(pal_rsp.lo[3:0]), nib2(pal_rsp.lo[7:4]), nib2(pal_rsp.hi[3:0])} : 24'd0;

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");
	a_rom_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rom_read |-> !palette_valid && side_event == EV_NONE && read_data == 8'd0)
		else $error("ROM read with side effects");
	a_evt_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_data != 8'd0 |-> side_event == EV_SOUND_CMD ||
			side_event == EV_MCU_WRITE)
		else $error("event data without data event");
	a_pal_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && palette_valid |-> wr_s1 && !rom_read)
		else $error("palette update on a read");

endmodule
